FILE: src/ecpu_pkg.sv
package ecpu_pkg;

    // Register file geometry.
    localparam int REG_COUNT  = 16;
    localparam int DATA_WIDTH = 8;
    localparam int REG_IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // Fixed byte width of the operand fields.
    localparam int BYTE_W     = 8;
    localparam int OPER_RANGE = 1 << BYTE_W;

    // Opcodes. Codes that are not listed here behave as a no-op.
    typedef enum logic [3:0] {
        OP_NOP   = 4'h0,
        OP_ADD   = 4'h1,
        OP_SUB   = 4'h2,
        OP_OR    = 4'h3,
        OP_NOT   = 4'h4,
        OP_AND   = 4'h5,
        OP_MUL   = 4'h6,
        OP_DIV   = 4'h7,
        OP_JE    = 4'h8,
        OP_JG    = 4'h9,
        OP_JL    = 4'hA,
        OP_JMP   = 4'hB,
        OP_PRINT = 4'hC,
        OP_HALT  = 4'hF
    } t_op;

    typedef logic [REG_IDX_W-1:0] t_idx_tab [OPER_RANGE];

    // Maps an operand byte to its register index (operand modulo REG_COUNT).
    // Built at elaboration, so the modulo costs nothing in hardware.
    function automatic t_idx_tab f_build_idx_tab();
        t_idx_tab tab;
        for (int i = 0; i < OPER_RANGE; i++) begin
            tab[i] = REG_IDX_W'(i % REG_COUNT);
        end
        return tab;
    endfunction

    localparam t_idx_tab IDX_TAB = f_build_idx_tab();

endpackage

FILE: src/ecpu_ram.sv
module ecpu_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/eight_bit_cpu_execute_unit_top.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+-----------------------------------------
// request   | in        | i_in_valid / o_in_stall | i_req_type, i_operand_a/_b/_c
// result    | out       | o_out_valid/i_out_stall | o_write_*, o_jump_*, o_print_*, o_halted
//
// A request moves from acceptance through S_RD_B, S_SETUP and S_EXEC to S_DONE, where its
// result loads; mul and div stay in S_EXEC and run one bit a cycle through the shared
// adder; both register reads use the one read port. The input stalls until the result
// loads, and after halt an accepted request goes straight to S_DONE.
// Reset is synchronous and active low; it clears the register valid bits and the halt flag.
// A stalled result holds in the output register while the next request is worked.
module eight_bit_cpu_execute_unit_top
    import ecpu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [3:0]        i_req_type,
    input  logic [BYTE_W-1:0] i_operand_a,
    input  logic [BYTE_W-1:0] i_operand_b,
    input  logic [BYTE_W-1:0] i_operand_c,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_write_valid,
    output logic [BYTE_W-1:0] o_write_value,
    output logic              o_jump_taken,
    output logic [BYTE_W-1:0] o_jump_target,
    output logic              o_print_valid,
    output logic [BYTE_W-1:0] o_print_value,
    output logic              o_halted
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_SETUP,
        S_EXEC,
        S_DONE
    } t_state;

    localparam int W = DATA_WIDTH;

    t_state                r_state;
    t_op                   r_op;
    logic                  r_halt;
    logic [REG_COUNT-1:0]  r_valid;
    logic [REG_IDX_W-1:0]  r_ib;
    logic [REG_IDX_W-1:0]  r_ic;
    logic [REG_IDX_W-1:0]  r_rd_idx;
    logic [BYTE_W-1:0]     r_a;
    logic [BYTE_W-1:0]     r_c;
    logic [W-1:0]          r_va;
    logic [W-1:0]          r_vb;
    logic [W-1:0]          r_acc;
    logic [W-1:0]          r_md;
    logic [W-1:0]          r_mq;
    logic [W-1:0]          r_res;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_wr;
    logic                  r_jmp;
    logic                  r_prt;

    logic                  r_o_valid;
    logic                  r_o_write_valid;
    logic [BYTE_W-1:0]     r_o_write_value;
    logic                  r_o_jump_taken;
    logic [BYTE_W-1:0]     r_o_jump_target;
    logic                  r_o_print_valid;
    logic [BYTE_W-1:0]     r_o_print_value;
    logic                  r_o_halted;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_finish;
    logic [REG_IDX_W-1:0]  w_rd_addr;
    logic [W-1:0]          w_rd_data;
    logic [W-1:0]          w_rd_value;
    logic                  w_wr_en;
    logic [W:0]            w_x;
    logic [W:0]            w_y;
    logic                  w_sub;
    logic [W+1:0]          w_sum;
    logic                  w_ge;
    logic                  w_eq;
    logic [W-1:0]          w_div_q;

    // Handshake on both sides.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    // Register file read address: operand a while accepting, then operand b.
    assign w_rd_addr = (r_state == S_IDLE) ? IDX_TAB[i_operand_a] : r_ib;

    // A register never written since reset reads as zero.
    assign w_rd_value = r_valid[r_rd_idx] ? w_rd_data : '0;

    assign w_wr_en = w_finish && r_wr;

    ecpu_ram #(
        .WIDTH (W),
        .DEPTH (REG_COUNT)
    ) u_reg_file (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_ic),
        .i_wr_data (r_res),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Operand selection for the shared adder/subtractor.
    always_comb begin
        w_x   = {1'b0, r_va};
        w_y   = {1'b0, r_vb};
        w_sub = 1'b0;
        unique case (r_op)
            OP_SUB, OP_JE, OP_JG, OP_JL: begin
                w_sub = 1'b1;
            end
            OP_MUL: begin
                w_x = {1'b0, r_acc};
                w_y = {1'b0, r_md};
            end
            OP_DIV: begin
                w_x   = {r_acc, r_mq[W-1]};
                w_sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Shared adder; the top bit is the no-borrow flag of a subtraction.
    assign w_sum   = {1'b0, w_x} + {1'b0, (w_sub ? ~w_y : w_y)} + (W+2)'(w_sub);
    assign w_ge    = w_sum[W+1];
    assign w_eq    = (w_sum[W:0] == '0);
    assign w_div_q = {r_mq[W-2:0], w_ge};

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_halt    <= 1'b0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_idx <= w_rd_addr;

            // The output register empties when its result is taken and no new one loads.
            if (r_o_valid && !i_out_stall && !w_finish) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op  <= t_op'(i_req_type);
                        r_ib  <= IDX_TAB[i_operand_b];
                        r_ic  <= IDX_TAB[i_operand_c];
                        r_a   <= i_operand_a;
                        r_c   <= i_operand_c;
                        r_wr  <= 1'b0;
                        r_jmp <= 1'b0;
                        r_prt <= 1'b0;
                        // Once halted, a request only reports the halt.
                        r_state <= r_halt ? S_DONE : S_RD_B;
                    end
                end
                S_RD_B: begin
                    r_va    <= w_rd_value;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_vb    <= w_rd_value;
                    r_md    <= w_rd_value;
                    r_mq    <= r_va;
                    r_acc   <= '0;
                    r_cnt   <= CNT_W'(W - 1);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // Mul and div stay here until their last bit is done.
                    r_state <= ((r_op == OP_MUL || r_op == OP_DIV) && r_cnt != '0) ?
                               S_EXEC : S_DONE;
                    unique case (r_op)
                        OP_ADD, OP_SUB: begin
                            r_res <= w_sum[W-1:0];
                            r_wr  <= 1'b1;
                        end
                        OP_OR: begin
                            r_res <= r_va | r_vb;
                            r_wr  <= 1'b1;
                        end
                        OP_AND: begin
                            r_res <= r_va & r_vb;
                            r_wr  <= 1'b1;
                        end
                        OP_NOT: begin
                            r_res <= W'(r_va == '0);
                            r_wr  <= 1'b1;
                        end
                        OP_MUL: begin
                            // Shift-add: one multiplier bit per cycle.
                            if (r_mq[0]) begin
                                r_acc <= w_sum[W-1:0];
                            end
                            r_md <= {r_md[W-2:0], 1'b0};
                            r_mq <= {1'b0, r_mq[W-1:1]};
                            if (r_cnt == '0) begin
                                r_res <= r_mq[0] ? w_sum[W-1:0] : r_acc;
                                r_wr  <= 1'b1;
                            end else begin
                                r_cnt <= r_cnt - 1'b1;
                            end
                        end
                        OP_DIV: begin
                            // Restoring division: one quotient bit per cycle.
                            // A zero divisor yields all ones on its own.
                            r_acc <= w_ge ? w_sum[W-1:0] : w_x[W-1:0];
                            r_mq  <= w_div_q;
                            if (r_cnt == '0) begin
                                r_res <= w_div_q;
                                r_wr  <= 1'b1;
                            end else begin
                                r_cnt <= r_cnt - 1'b1;
                            end
                        end
                        OP_JE: begin
                            r_jmp <= w_eq;
                        end
                        OP_JG: begin
                            r_jmp <= w_ge && !w_eq;
                        end
                        OP_JL: begin
                            r_jmp <= !w_ge;
                        end
                        OP_JMP: begin
                            r_jmp <= 1'b1;
                        end
                        OP_PRINT: begin
                            r_prt <= 1'b1;
                        end
                        OP_HALT: begin
                            r_halt <= 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                S_DONE: begin
                    // Load the result once the output register is free.
                    if (w_out_free) begin
                        r_o_valid       <= 1'b1;
                        r_o_write_valid <= r_wr;
                        r_o_write_value <= r_wr ? r_res[BYTE_W-1:0] : '0;
                        r_o_jump_taken  <= r_jmp;
                        r_o_jump_target <= r_jmp ? r_c : '0;
                        r_o_print_valid <= r_prt;
                        r_o_print_value <= r_prt ? r_a : '0;
                        r_o_halted      <= r_halt;
                        if (r_wr) begin
                            r_valid[r_ic] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_write_valid = r_o_write_valid;
    assign o_write_value = r_o_write_value;
    assign o_jump_taken  = r_o_jump_taken;
    assign o_jump_target = r_o_jump_target;
    assign o_print_valid = r_o_print_valid;
    assign o_print_value = r_o_print_value;
    assign o_halted      = r_o_halted;

    // The halt flag never clears outside reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // A request taken while halted skips execution entirely.
    a_halt_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_halt) |=> (r_state == S_DONE))
        else $error("request after halt was executed");

    // A result carries at most one kind of effect.
    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones({o_write_valid, o_jump_taken, o_print_valid}) <= 1))
        else $error("result carries more than one effect");

    // A register is written only in the cycle a result is loaded.
    a_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (o_out_valid && o_write_valid))
        else $error("register write without a matching result");

endmodule
